// ===== rtl/pfs_pkg.sv =====
// Shared types, constants and helpers for the prime factorization unit.
// Depends on nothing; every other file but pfs_div imports it.
package pfs_pkg;

   localparam int VALUE_WIDTH       = 16;
   localparam int MAX_TABLE_LIMIT   = (2 ** VALUE_WIDTH) - 1;
   localparam int DEFAULT_MAX_VALUE = 65535;
   localparam int QUEUE_DEPTH       = 2;

   // One classified input waiting for the factoring engine.
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   empty;
   } queue_entry_type;

   // Read request into the smallest-factor table.
   typedef struct packed {
      logic                   en;
      logic [VALUE_WIDTH-1:0] addr;
   } lookup_req_type;

   // Largest index the table covers; the input is only 16 bits wide.
   function automatic int table_limit(input int max_value);
      return (max_value < MAX_TABLE_LIMIT) ? max_value : MAX_TABLE_LIMIT;
   endfunction

endpackage

// ===== rtl/prime_factorization_spf_sieve_unit.sv =====
// Top level of the prime factorization unit: smallest-factor table, front end
// and factoring back end. Depends on pfs_pkg, pfs_table, pfs_front, pfs_back.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_ready    req_value[15:0]
//   rsp       out        rsp_valid/rsp_ready    rsp_factor[15:0], rsp_is_last,
//                                               rsp_empty_res
//
// After reset the table is built before any beat is taken: every entry is seeded
// with its own index (65,536 entries at the default limit), then the sieve visits
// the table with a read state and a check state per visit.
// Each prime factor takes a table read, a divide (one quotient bit per cycle in
// the back end's divider) and a load of the output register, which waits while
// an earlier result beat is held by rsp_ready. An empty result skips the table
// and the divider. The two-entry queue keeps accepting requests, until it is
// full, while the back end works or a result beat waits on rsp_ready.
module prime_factorization_spf_sieve_unit
   import pfs_pkg::*;
#(
   parameter int MAX_VALUE = DEFAULT_MAX_VALUE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [VALUE_WIDTH-1:0] rsp_factor,
   output logic                   rsp_is_last,
   output logic                   rsp_empty_res
);

   localparam int LIMIT = table_limit(MAX_VALUE);
   localparam int AW    = $clog2(LIMIT + 1);

   lookup_req_type  lk;
   logic [AW-1:0]   lk_data;
   logic            table_done;
   queue_entry_type head;
   logic            head_valid;
   logic            pop;

   // Table memory and its sieve; it serves lookups once the sieve is done.
   pfs_table #(
      .MAX_VALUE(MAX_VALUE)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .lk     (lk),
      .lk_data(lk_data),
      .done   (table_done)
   );

   // Request beats are classified here and parked in a short queue.
   pfs_front #(
      .MAX_VALUE(MAX_VALUE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .table_ready(table_done),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // The back end repeatedly looks up the smallest factor and divides it out,
   // sending one result beat per factor in nondecreasing order.
   pfs_back #(
      .MAX_VALUE(MAX_VALUE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .pop          (pop),
      .lk           (lk),
      .lk_data      (lk_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_factor   (rsp_factor),
      .rsp_is_last  (rsp_is_last),
      .rsp_empty_res(rsp_empty_res)
   );

endmodule

// ===== rtl/pfs_table.sv =====
// Smallest-prime-factor table: memory, post-reset sieve and the lookup port.
// Depends on pfs_pkg.
module pfs_table
   import pfs_pkg::*;
#(
   parameter int MAX_VALUE = DEFAULT_MAX_VALUE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lookup_req_type                        lk,
   output logic [$clog2(table_limit(MAX_VALUE)+1)-1:0] lk_data,
   output logic                                  done
);

   localparam int LIMIT = table_limit(MAX_VALUE);
   localparam int AW    = $clog2(LIMIT + 1);
   localparam int DEPTH = LIMIT + 1;
   localparam logic [AW-1:0]   LIMIT_A  = AW'(LIMIT);
   localparam logic [AW:0]     LIMIT_K  = (AW + 1)'(LIMIT);
   localparam logic [2*AW-1:0] LIMIT_SQ = (2 * AW)'(LIMIT);

   localparam logic [2:0] ST_INIT      = 3'd0;
   localparam logic [2:0] ST_PRIME_RD  = 3'd1;
   localparam logic [2:0] ST_PRIME_CHK = 3'd2;
   localparam logic [2:0] ST_MARK_RD   = 3'd3;
   localparam logic [2:0] ST_MARK_CHK  = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;

   logic [AW-1:0] mem [DEPTH];

   logic [2:0]      state_ff, state_in;
   logic [AW-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]   p_ff, p_in;
   logic [2*AW-1:0] sq_ff, sq_in;
   logic [AW:0]     k_ff, k_in;
   logic [AW-1:0]   rd_data_ff;

   logic            mem_we, mem_re;
   logic [AW-1:0]   mem_waddr, mem_wdata, mem_raddr;
   logic [2*AW-1:0] p_wide;
   logic [AW:0]     k_next;

   assign p_wide = {{AW{1'b0}}, p_ff};
   assign k_next = k_ff + {1'b0, p_ff};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      p_in      = p_ff;
      sq_in     = sq_ff;
      k_in      = k_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = cnt_ff;
      mem_raddr = p_ff;
      case (state_ff)
         ST_INIT: begin
            // Every entry starts as its own index.
            mem_we = 1'b1;
            if (cnt_ff == LIMIT_A) begin
               p_in     = AW'(2);
               state_in = ST_PRIME_RD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PRIME_RD: begin
            mem_re   = 1'b1;
            sq_in    = p_wide * p_wide;
            state_in = ST_PRIME_CHK;
         end
         ST_PRIME_CHK: begin
            if (sq_ff > LIMIT_SQ) begin
               state_in = ST_DONE;
            end else if (rd_data_ff == p_ff) begin
               k_in     = sq_ff[AW:0];
               state_in = ST_MARK_RD;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = ST_PRIME_RD;
            end
         end
         ST_MARK_RD: begin
            mem_re    = 1'b1;
            mem_raddr = k_ff[AW-1:0];
            state_in  = ST_MARK_CHK;
         end
         ST_MARK_CHK: begin
            // Only entries still holding their own index take this prime.
            if (rd_data_ff == k_ff[AW-1:0]) begin
               mem_we    = 1'b1;
               mem_waddr = k_ff[AW-1:0];
               mem_wdata = p_ff;
            end
            if (k_next > LIMIT_K) begin
               p_in     = p_ff + 1'b1;
               state_in = ST_PRIME_RD;
            end else begin
               k_in     = k_next;
               state_in = ST_MARK_RD;
            end
         end
         ST_DONE: begin
            mem_re    = lk.en;
            mem_raddr = lk.addr[AW-1:0];
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         cnt_ff   <= '0;
         p_ff     <= '0;
         sq_ff    <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         p_ff     <= p_in;
         sq_ff    <= sq_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign lk_data = rd_data_ff;
   assign done    = (state_ff == ST_DONE);

`ifndef NO_ASSERTIONS
   a_no_write_after_sieve: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !mem_we)
      else $error("table written after the sieve finished");
   a_lookup_only_when_done: assert property (@(posedge clock) disable iff (reset)
      lk.en |-> (state_ff == ST_DONE))
      else $error("lookup issued while the sieve is running");
   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK_CHK) |-> (k_ff <= LIMIT_K))
      else $error("sieve marking beyond the table limit");
`endif

endmodule

// ===== rtl/pfs_front.sv =====
// Front end: accepts request beats, classifies them and queues them.
// Depends on pfs_pkg.
module pfs_front
   import pfs_pkg::*;
#(
   parameter int MAX_VALUE = DEFAULT_MAX_VALUE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   table_ready,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   pop,
   output queue_entry_type        head,
   output logic                   head_valid
);

   localparam int LIMIT = table_limit(MAX_VALUE);
   localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam logic [VALUE_WIDTH-1:0] LIMIT_V = VALUE_WIDTH'(LIMIT);
   localparam logic [PW-1:0]          LAST_P  = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0]          FULL_C  = CW'(QUEUE_DEPTH);

   queue_entry_type entries [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            push, do_pop;
   queue_entry_type new_entry;

   assign req_ready  = table_ready && (count_ff != FULL_C);
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign do_pop     = pop && head_valid;
   assign head       = entries[rd_ptr_ff];

   // Zero, one and anything beyond the table give the empty result.
   always_comb begin
      new_entry.value = req_value;
      new_entry.empty = (req_value <= VALUE_WIDTH'(1)) || (req_value > LIMIT_V);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_P) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_P) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/pfs_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module pfs_div #(
   parameter int WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
   localparam logic [CW-1:0] LAST_STEP = CW'(WIDTH - 1);

   logic             busy_ff, done_ff;
   logic [CW-1:0]    step_ff;
   logic [WIDTH-1:0] rem_ff, dvd_ff, dsr_ff;
   logic [WIDTH:0]   trial, diff;

   assign trial = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_ff <= diff[WIDTH-1:0];
            dvd_ff <= {dvd_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_ff <= trial[WIDTH-1:0];
            dvd_ff <= {dvd_ff[WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== rtl/pfs_back.sv =====
// Back end: walks one queued value through table lookups and divisions.
// Depends on pfs_pkg and pfs_div.
module pfs_back
   import pfs_pkg::*;
#(
   parameter int MAX_VALUE = DEFAULT_MAX_VALUE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  queue_entry_type                       head,
   input  logic                                  head_valid,
   output logic                                  pop,
   output lookup_req_type                        lk,
   input  logic [$clog2(table_limit(MAX_VALUE)+1)-1:0] lk_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [VALUE_WIDTH-1:0]                rsp_factor,
   output logic                                  rsp_is_last,
   output logic                                  rsp_empty_res
);

   localparam int LIMIT = table_limit(MAX_VALUE);
   localparam int AW    = $clog2(LIMIT + 1);

   localparam logic [2:0] BK_IDLE = 3'd0;
   localparam logic [2:0] BK_LOOK = 3'd1;
   localparam logic [2:0] BK_READ = 3'd2;
   localparam logic [2:0] BK_DIV  = 3'd3;
   localparam logic [2:0] BK_EMIT = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [AW-1:0]          rem_ff, rem_in;
   logic [AW-1:0]          d_ff, d_in;
   logic                   empty_ff, empty_in;
   logic                   last_ff, last_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_factor_ff;
   logic                   rsp_is_last_ff, rsp_empty_ff;
   logic                   load_rsp;
   logic                   div_start, div_done;
   logic [AW-1:0]          div_q;

   pfs_div #(
      .WIDTH(AW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(rem_ff),
      .divisor (lk_data),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      d_in      = d_ff;
      empty_in  = empty_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      lk.en     = 1'b0;
      lk.addr   = VALUE_WIDTH'(rem_ff);
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head.empty) begin
                  empty_in = 1'b1;
                  last_in  = 1'b1;
                  d_in     = '0;
                  state_in = BK_EMIT;
               end else begin
                  empty_in = 1'b0;
                  rem_in   = head.value[AW-1:0];
                  state_in = BK_LOOK;
               end
            end
         end
         BK_LOOK: begin
            lk.en    = 1'b1;
            state_in = BK_READ;
         end
         BK_READ: begin
            d_in      = lk_data;
            div_start = 1'b1;
            state_in  = BK_DIV;
         end
         BK_DIV: begin
            if (div_done) begin
               rem_in   = div_q;
               last_in  = (div_q <= AW'(1));
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = last_ff ? BK_IDLE : BK_LOOK;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      d_ff     <= d_in;
      empty_ff <= empty_in;
      last_ff  <= last_in;
      if (load_rsp) begin
         rsp_factor_ff  <= VALUE_WIDTH'(d_ff);
         rsp_is_last_ff <= last_ff;
         rsp_empty_ff   <= empty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_factor    = rsp_factor_ff;
   assign rsp_is_last   = rsp_is_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

`ifndef NO_ASSERTIONS
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == BK_DIV))
      else $error("divider finished outside the divide state");
   a_factor_is_prime_sized: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_empty_ff) |-> (rsp_factor_ff >= VALUE_WIDTH'(2)))
      else $error("factor below two on a non-empty result");
   a_empty_is_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_is_last_ff && (rsp_factor_ff == '0)))
      else $error("empty result must be a lone zero beat");
`endif

endmodule
